### rtl/npc_pkg.sv
package npc_pkg;

	localparam int NUM_W           = 16;
	localparam int LEN_W           = 16;
	localparam int MASK_W          = 14;
	localparam int RC_W            = 17;
	localparam int DIV_STEPS       = 4;
	localparam int DEF_TABLE_DEPTH = 65536;
	localparam logic [RC_W-1:0] RC_RESET = 17'd65536;

	localparam logic KIND_LOAD     = 1'b0;
	localparam logic KIND_CLASSIFY = 1'b1;

	localparam int MB_PRIME    = 0;
	localparam int MB_SAFE     = 1;
	localparam int MB_POPHIGH  = 2;
	localparam int MB_PEAK     = 3;
	localparam int MB_FIB      = 4;
	localparam int MB_FACTOR   = 5;
	localparam int MB_SQUARE   = 6;
	localparam int MB_SQFREE   = 7;
	localparam int MB_TRI      = 8;
	localparam int MB_POW2     = 9;
	localparam int MB_MERSENNE = 10;
	localparam int MB_PALIN    = 11;
	localparam int MB_MANYDIV  = 12;
	localparam int MB_SMALLPOW = 13;

	typedef struct packed {
		logic             kind;
		logic [NUM_W-1:0] number;
		logic [LEN_W-1:0] chain_length;
	} req_t;

	typedef struct packed {
		logic [MASK_W-1:0] property_mask;
		logic              in_range;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic run;
	} div_ctl_t;

	localparam int FIB_N = 22;
	localparam logic [NUM_W-1:0] FIB_TAB [FIB_N] = '{
		16'd2, 16'd3, 16'd5, 16'd8, 16'd13, 16'd21, 16'd34, 16'd55, 16'd89, 16'd144,
		16'd233, 16'd377, 16'd610, 16'd987, 16'd1597, 16'd2584, 16'd4181, 16'd6765,
		16'd10946, 16'd17711, 16'd28657, 16'd46368
	};

	localparam int POW_N = 29;
	localparam logic [NUM_W-1:0] POW_TAB [POW_N] = '{
		16'd9, 16'd27, 16'd81, 16'd243, 16'd729, 16'd2187, 16'd6561, 16'd19683, 16'd59049,
		16'd16, 16'd64, 16'd256, 16'd1024, 16'd4096, 16'd16384,
		16'd25, 16'd125, 16'd625, 16'd3125, 16'd15625,
		16'd36, 16'd216, 16'd1296, 16'd7776, 16'd46656,
		16'd49, 16'd343, 16'd2401, 16'd16807
	};

	function automatic logic is_fib(logic [NUM_W-1:0] v);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < FIB_N; i++) begin
			if (v == FIB_TAB[i]) hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic is_small_pow(logic [NUM_W-1:0] v);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < POW_N; i++) begin
			if (v == POW_TAB[i]) hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic [4:0] bit_len(logic [NUM_W-1:0] v);
		logic [4:0] len;
		len = 5'd0;
		for (int i = 0; i < NUM_W; i++) begin
			if (v[i]) len = 5'(i + 1);
		end
		return len;
	endfunction

	function automatic logic [4:0] pop_count(logic [NUM_W-1:0] v);
		logic [4:0] cnt;
		cnt = 5'd0;
		for (int i = 0; i < NUM_W; i++) begin
			cnt = cnt + 5'(v[i]);
		end
		return cnt;
	endfunction

	function automatic logic is_palin(logic [NUM_W-1:0] v);
		logic [NUM_W-1:0] rev;
		logic [4:0]       len;
		for (int i = 0; i < NUM_W; i++) begin
			rev[i] = v[NUM_W-1-i];
		end
		len = bit_len(v);
		return (rev >> (5'd16 - len)) == v;
	endfunction

endpackage

### rtl/number_property_classifier.sv
// channel   direction  signals                      moves
// req       in         req_valid req_ready req      load or classify request
// rsp       out        rsp_valid rsp_ready rsp      property mask, in-range flag
// cfg       in         cfg_valid cfg_ready cfg_data record_count write
//
// A load writes the length table and leaves the block idle. A classify outside
// the record range goes straight to the finish state. In range, a classify reads
// the table, takes isqrt(n), then trial-divides with three divider lanes at 4 quotient bits per cycle.
// Reset sets record_count to 65536; the length table is not cleared.
// A finished result waits in the output register; the next request is taken meanwhile.
module number_property_classifier #(
	parameter int TABLE_DEPTH = npc_pkg::DEF_TABLE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  npc_pkg::req_t            req,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output npc_pkg::rsp_t            rsp,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [npc_pkg::RC_W-1:0] cfg_data
);
	import npc_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [RC_W-1:0] DEPTH_L = RC_W'(TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_RN, S_RM, S_RP, S_RW, S_SQRT, S_DIV, S_EVAL,
		S_RF1, S_RF2, S_RF3, S_FIN
	} state_t;

	state_t           state_q;
	logic [RC_W-1:0]  rc_q;
	logic [NUM_W-1:0] n_q, m_q, q_q;
	logic             rng_q, rd_ok_q;
	logic [LEN_W-1:0] ln_q, lm_q, lp1_q, lfp_q, lfq_q;
	logic [8:0]       d_q;
	logic [RC_W-1:0]  sq_q;
	logic [1:0]       cnt_q;
	logic [7:0]       p_q, divs_q;
	logic             found_q, sqhit_q, nsf_q, mdiv_q;
	logic [18:0]      sv_q, sres_q, sbit_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic             req_fire, ram_we;
	logic [RC_W-1:0]  rd_idx;
	logic [LEN_W-1:0] ram_rdata, rd_val;
	logic [8:0]       d_next;
	logic [RC_W-1:0]  sq_next, n_ext, np1;
	logic             more, lane_load;
	logic [NUM_W-1:0] dv_d, dv_sq;
	div_ctl_t         lane_ctl;
	logic [NUM_W-1:0] quo_a, rem_a, quo_b, rem_b, quo_c, rem_c;
	logic [18:0]      stry;
	logic [MASK_W-1:0] mask;
	logic             isp, out_free;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign out_free  = !out_valid_q || rsp_ready;

	assign n_ext = {1'b0, n_q};
	assign np1   = n_ext + 17'd1;
	assign ram_we = req_fire && (req.kind == KIND_LOAD) && ({1'b0, req.number} < DEPTH_L);

	always_comb begin
		unique case (state_q)
			S_RN:    rd_idx = n_ext;
			S_RM:    rd_idx = n_ext - 17'd1;
			S_RP:    rd_idx = np1;
			S_RF1:   rd_idx = {9'd0, p_q};
			S_RF2:   rd_idx = {1'b0, q_q};
			default: rd_idx = n_ext;
		endcase
	end

	npc_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.number[AW-1:0]),
		.wdata (req.chain_length),
		.raddr (rd_idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	// entries past the table read as zero
	assign rd_val = rd_ok_q ? ram_rdata : '0;

	assign d_next  = d_q + 9'd1;
	assign sq_next = sq_q + {7'd0, d_q, 1'b1};
	assign more    = (sq_next <= n_ext);

	always_comb begin
		if (state_q == S_EVAL) begin
			dv_d  = {7'd0, d_next};
			dv_sq = sq_next[NUM_W-1:0];
		end else begin
			dv_d  = 16'd1;
			dv_sq = 16'd1;
		end
	end

	assign lane_load = ((state_q == S_SQRT) && sbit_q[0]) || ((state_q == S_EVAL) && more);
	assign lane_ctl  = '{load: lane_load, run: (state_q == S_DIV)};

	npc_div u_div_a (.clk(clk), .ctl(lane_ctl), .dividend(n_q), .divisor(dv_d),
		.quotient(quo_a), .remainder(rem_a));
	npc_div u_div_b (.clk(clk), .ctl(lane_ctl), .dividend(n_q), .divisor(dv_sq),
		.quotient(quo_b), .remainder(rem_b));
	npc_div u_div_c (.clk(clk), .ctl(lane_ctl), .dividend(m_q), .divisor(dv_d),
		.quotient(quo_c), .remainder(rem_c));

	assign stry = sres_q + sbit_q;

	always_comb begin
		isp  = !found_q;
		mask = '0;
		mask[MB_PRIME]    = isp;
		mask[MB_SAFE]     = isp && (m_q >= 16'd2) && !mdiv_q;
		mask[MB_POPHIGH]  = pop_count(n_q) > (bit_len(n_q) >> 1);
		mask[MB_PEAK]     = (n_q > 16'd2) && (np1 < rc_q) && (ln_q > lm_q) && (ln_q > lp1_q);
		mask[MB_FIB]      = is_fib(n_q);
		mask[MB_FACTOR]   = !isp && (n_q > 16'd3) &&
			({1'b0, ln_q} == ({1'b0, lfp_q} + {1'b0, lfq_q}));
		mask[MB_SQUARE]   = sqhit_q;
		mask[MB_SQFREE]   = !nsf_q;
		mask[MB_TRI]      = (sv_q == '0);
		mask[MB_POW2]     = ((n_q & (n_q - 16'd1)) == '0);
		mask[MB_MERSENNE] = ((np1 & n_ext) == '0);
		mask[MB_PALIN]    = is_palin(n_q);
		mask[MB_MANYDIV]  = (divs_q >= 8'd12);
		mask[MB_SMALLPOW] = is_small_pow(n_q);
	end

	always_ff @(posedge clk) begin
		rd_ok_q <= (rd_idx < DEPTH_L);
		unique case (state_q)
			S_IDLE: begin
				n_q <= req.number;
				m_q <= (req.number - 16'd1) >> 1;
			end
			S_RM: ln_q <= rd_val;
			S_RP: lm_q <= rd_val;
			S_RW: begin
				lp1_q  <= rd_val;
				sv_q   <= {n_q, 3'b001};
				sres_q <= '0;
				sbit_q <= 19'h40000;
			end
			S_SQRT: begin
				if (sv_q >= stry) begin
					sv_q   <= sv_q - stry;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				d_q     <= 9'd1;
				sq_q    <= 17'd1;
				found_q <= 1'b0;
				sqhit_q <= 1'b0;
				nsf_q   <= 1'b0;
				mdiv_q  <= 1'b0;
				divs_q  <= '0;
				p_q     <= '0;
				cnt_q   <= '0;
			end
			S_DIV: cnt_q <= cnt_q + 2'd1;
			S_EVAL: begin
				if (rem_a == '0) begin
					divs_q <= divs_q + ((sq_q == n_ext) ? 8'd1 : 8'd2);
					if (sq_q == n_ext) sqhit_q <= 1'b1;
					if (d_q >= 9'd2 && !found_q) begin
						found_q <= 1'b1;
						p_q     <= d_q[7:0];
						q_q     <= quo_a;
					end
				end
				if (d_q >= 9'd2 && rem_b == '0) nsf_q <= 1'b1;
				if (d_q >= 9'd2 && rem_c == '0 && sq_q <= {1'b0, m_q}) mdiv_q <= 1'b1;
				d_q   <= d_next;
				sq_q  <= sq_next;
				cnt_q <= '0;
			end
			S_RF2: lfp_q <= rd_val;
			S_RF3: lfq_q <= rd_val;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rc_q        <= RC_RESET;
			rng_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) rc_q <= cfg_data;
			if (out_valid_q && rsp_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_fire && req.kind == KIND_CLASSIFY) begin
						rng_q <= (req.number >= 16'd2) && ({1'b0, req.number} < rc_q);
						if ((req.number >= 16'd2) && ({1'b0, req.number} < rc_q))
							state_q <= S_RN;
						else
							state_q <= S_FIN;
					end
				end
				S_RN:   state_q <= S_RM;
				S_RM:   state_q <= S_RP;
				S_RP:   state_q <= S_RW;
				S_RW:   state_q <= S_SQRT;
				S_SQRT: if (sbit_q[0]) state_q <= S_DIV;
				S_DIV:  if (cnt_q == 2'd3) state_q <= S_EVAL;
				S_EVAL: state_q <= more ? S_DIV : S_RF1;
				S_RF1:  state_q <= S_RF2;
				S_RF2:  state_q <= S_RF3;
				S_RF3:  state_q <= S_FIN;
				S_FIN: begin
					// hold until the output register frees up
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.property_mask <= rng_q ? mask : '0;
						out_q.in_range      <= rng_q;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.in_range |-> rsp.property_mask == '0)
		else $error("out-of-range result carries a mask");
	a_safe_is_prime: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.property_mask[MB_SAFE] |-> rsp.property_mask[MB_PRIME])
		else $error("safe prime without prime");
	a_prime_no_factor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.property_mask[MB_PRIME] && rsp.property_mask[MB_FACTOR]))
		else $error("prime with factor match");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_IDLE)
		else $error("table write during classify");
`endif

endmodule

### rtl/npc_ram.sv
module npc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### rtl/npc_div.sv
module npc_div (
	input  logic                      clk,
	input  npc_pkg::div_ctl_t         ctl,
	input  logic [npc_pkg::NUM_W-1:0] dividend,
	input  logic [npc_pkg::NUM_W-1:0] divisor,
	output logic [npc_pkg::NUM_W-1:0] quotient,
	output logic [npc_pkg::NUM_W-1:0] remainder
);
	import npc_pkg::*;

	logic [NUM_W-1:0] rem_q, dq_q, dv_q;
	logic [NUM_W-1:0] rem_n, dq_n;

	// restoring division, DIV_STEPS quotient bits per cycle while run is set
	always_comb begin
		logic [NUM_W:0] t;
		rem_n = rem_q;
		dq_n  = dq_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t    = {rem_n, dq_n[NUM_W-1]};
			dq_n = {dq_n[NUM_W-2:0], 1'b0};
			if (t >= {1'b0, dv_q}) begin
				t       = t - {1'b0, dv_q};
				dq_n[0] = 1'b1;
			end
			rem_n = t[NUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dv_q  <= divisor;
		end else if (ctl.run) begin
			rem_q <= rem_n;
			dq_q  <= dq_n;
		end
	end

	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule
